### rtl/core/plin_pkg.sv
`timescale 1ns / 1ps

package plin_pkg;

  localparam int unsigned DATA_W         = 16;
  localparam int unsigned CFG_W          = 5;
  localparam int unsigned IDX_IN_W       = 4;
  localparam int unsigned PROD_W         = 2 * DATA_W;
  localparam int unsigned BIT_CNT_W      = $clog2(PROD_W);
  localparam int unsigned MAX_POINTS_DEF = 16;
  localparam logic [CFG_W-1:0] POINT_COUNT_RST = CFG_W'(1);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_TEST,
    S_MUL,
    S_DIV,
    S_FIN,
    S_DONE
  } state_e;

endpackage

### rtl/core/piecewise_linear_interpolator.sv
`timescale 1ns / 1ps

// Piecewise linear function evaluator over a table of (x, y) breakpoints.
// Command channel: start_i with command_i and its fields is taken when busy_o
// is low. A load writes one breakpoint in the accept cycle, returns no result
// and leaves busy_o low. An evaluate raises busy_o and scans the breakpoints
// in slot order, each with one table read and one compare, then for an
// interior point does one multiply, a 32-bit restoring divide on its own
// subtract/compare unit and one add of the base. A new command can be taken
// in the cycle after the result.
// Result channel: value_o is valid for exactly one cycle with value_valid_o;
// the receiver cannot stall it.
// Configuration channel: cfg_data_i sets the number of breakpoints in use;
// cfg_ready_o is high while no evaluate is in flight.
// Reset: the count returns to one and the sequencer to idle; breakpoint
// contents are undefined until loaded.
module piecewise_linear_interpolator #(
  parameter int unsigned MAX_POINTS = plin_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                command_i,
  input  logic [plin_pkg::IDX_IN_W-1:0]       point_index_i,
  input  logic signed [plin_pkg::DATA_W-1:0]  point_x_i,
  input  logic signed [plin_pkg::DATA_W-1:0]  point_y_i,
  input  logic signed [plin_pkg::DATA_W-1:0]  sample_i,
  output logic signed [plin_pkg::DATA_W-1:0]  value_o,
  output logic                                value_valid_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [plin_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned DW    = plin_pkg::DATA_W;
  localparam int unsigned PW    = plin_pkg::PROD_W;
  localparam int unsigned BW    = plin_pkg::BIT_CNT_W;

  plin_pkg::state_e state_q, state_d;

  logic [plin_pkg::CFG_W-1:0] point_count_q;
  logic [CNT_W-1:0]           n_used;
  logic [CNT_W-1:0]           i_q;

  logic [DW-1:0] xmem [MAX_POINTS];
  logic [DW-1:0] ymem [MAX_POINTS];
  logic signed [DW-1:0] rd_x_q, rd_y_q;

  logic signed [DW-1:0] sample_q, x0_q, y0_q;
  logic [DW-1:0]        ds_q, dy_mag_q, den_q, rem_q;
  logic                 neg_q;
  logic [PW-1:0]        quo_q;
  logic [BW-1:0]        bit_q;
  logic signed [DW-1:0] value_q;

  logic accept, wr_en, rd_en, ge, last, first, cfg_wr;
  logic [IDX_W-1:0] wr_addr;

  logic signed [DW:0] den_w, ds_w, dy_w, dy_abs_w;
  logic [PW-1:0]      prod_w;
  logic [DW:0]        shifted_w;
  logic               div_ge;
  logic [DW:0]        div_diff_w;
  logic [DW-1:0]      q_signed_w;

  assign accept  = start_i && !busy_o;
  assign wr_en   = accept && (command_i == plin_pkg::CMD_LOAD) &&
                   (32'(point_index_i) < MAX_POINTS);
  assign wr_addr = IDX_W'(point_index_i);
  assign cfg_wr  = cfg_valid_i && cfg_ready_o;

  always_comb begin
    if (point_count_q == '0) begin
      n_used = CNT_W'(1);
    end else if (32'(point_count_q) > MAX_POINTS) begin
      n_used = CNT_W'(MAX_POINTS);
    end else begin
      n_used = CNT_W'(point_count_q);
    end
  end

  assign ge    = sample_q >= rd_x_q;
  assign last  = CNT_W'(i_q + 1'b1) == n_used;
  assign first = i_q == '0;

  assign den_w    = {rd_x_q[DW-1], rd_x_q} - {x0_q[DW-1], x0_q};
  assign ds_w     = {sample_q[DW-1], sample_q} - {x0_q[DW-1], x0_q};
  assign dy_w     = {rd_y_q[DW-1], rd_y_q} - {y0_q[DW-1], y0_q};
  assign dy_abs_w = dy_w[DW] ? -dy_w : dy_w;
  assign prod_w   = ds_q * dy_mag_q;

  assign shifted_w  = {rem_q, quo_q[PW-1]};
  assign div_ge     = shifted_w >= {1'b0, den_q};
  assign div_diff_w = shifted_w - {1'b0, den_q};

  assign q_signed_w = neg_q ? (DW'(0) - quo_q[DW-1:0]) : quo_q[DW-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      plin_pkg::S_IDLE: begin
        if (accept && (command_i == plin_pkg::CMD_EVAL)) state_d = plin_pkg::S_FETCH;
      end
      plin_pkg::S_FETCH: state_d = plin_pkg::S_TEST;
      plin_pkg::S_TEST: begin
        if (ge) begin
          state_d = last ? plin_pkg::S_DONE : plin_pkg::S_FETCH;
        end else begin
          state_d = first ? plin_pkg::S_DONE : plin_pkg::S_MUL;
        end
      end
      plin_pkg::S_MUL: state_d = plin_pkg::S_DIV;
      plin_pkg::S_DIV: begin
        if (bit_q == '0) state_d = plin_pkg::S_FIN;
      end
      plin_pkg::S_FIN:  state_d = plin_pkg::S_DONE;
      plin_pkg::S_DONE: state_d = plin_pkg::S_IDLE;
      default:          state_d = plin_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy_o        = state_q != plin_pkg::S_IDLE;
    rd_en         = state_q == plin_pkg::S_FETCH;
    value_valid_o = state_q == plin_pkg::S_DONE;
    cfg_ready_o   = state_q == plin_pkg::S_IDLE;
  end

  assign value_o = value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= plin_pkg::S_IDLE;
      point_count_q <= plin_pkg::POINT_COUNT_RST;
    end else begin
      state_q <= state_d;
      if (cfg_wr) point_count_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      xmem[wr_addr] <= point_x_i;
      ymem[wr_addr] <= point_y_i;
    end
    if (rd_en) begin
      rd_x_q <= xmem[i_q[IDX_W-1:0]];
      rd_y_q <= ymem[i_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      plin_pkg::S_IDLE: begin
        sample_q <= sample_i;
        i_q      <= '0;
      end
      plin_pkg::S_TEST: begin
        if (ge) begin
          x0_q    <= rd_x_q;
          y0_q    <= rd_y_q;
          i_q     <= CNT_W'(i_q + 1'b1);
          value_q <= rd_y_q;
        end else begin
          value_q  <= rd_y_q;
          den_q    <= den_w[DW-1:0];
          ds_q     <= ds_w[DW-1:0];
          dy_mag_q <= dy_abs_w[DW-1:0];
          neg_q    <= dy_w[DW];
        end
      end
      plin_pkg::S_MUL: begin
        quo_q <= prod_w;
        rem_q <= '0;
        bit_q <= BW'(PW - 1);
      end
      plin_pkg::S_DIV: begin
        rem_q <= div_ge ? div_diff_w[DW-1:0] : shifted_w[DW-1:0];
        quo_q <= {quo_q[PW-2:0], div_ge};
        bit_q <= BW'(bit_q - 1'b1);
      end
      plin_pkg::S_FIN: begin
        value_q <= y0_q + q_signed_w;
      end
      default: begin
      end
    endcase
  end

  a_eval_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (command_i == plin_pkg::CMD_EVAL) |=> busy_o)
    else $error("evaluate accepted without entering the scan");

  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (command_i == plin_pkg::CMD_LOAD) |=> !busy_o && !value_valid_o)
    else $error("load caused activity or a result");

  a_result_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    value_valid_o |=> !busy_o && !value_valid_o)
    else $error("result strobe not followed by idle");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == plin_pkg::S_FETCH) |-> (i_q < n_used))
    else $error("scan index past the breakpoints in use");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == plin_pkg::S_DIV) |-> (den_q != '0))
    else $error("divide started with a zero divisor");

endmodule
